>>> hdl/gyro_rate_from_delta_angle_top_defines.svh
// Assertion macros shared by the gyro rate checker.
`ifndef GYRO_RATE_FROM_DELTA_ANGLE_TOP_DEFINES_SVH
`define GYRO_RATE_FROM_DELTA_ANGLE_TOP_DEFINES_SVH

// same-cycle implication
`define GRFDA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define GRFDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

>>> hdl/grfda_pkg.sv
// Shared types and constants of the gyro rate block.
package grfda_pkg;

	localparam int TIME_W  = 48;
	localparam int COUNT_W = 32;
	localparam int DIRECT_W = 24;
	localparam int BIAS_W  = 32;
	localparam int RATE_W  = 36;
	localparam int NUM_W   = 52;
	localparam int QUO_W   = 28;
	localparam int LIM_W   = 40;
	localparam int DIV_STEPS = QUO_W;
	localparam int CFG_IDX_W = 2;
	localparam int IN_DATA_W  = 216;
	localparam int OUT_DATA_W = 160;

	localparam logic [COUNT_W-1:0] STEP_LIMIT     = 32'h7fff_ffff;
	localparam logic [7:0]         MAX_RATE_RAD   = 8'd157;
	localparam logic [19:0]        URAD_PER_RAD   = 20'd1000000;
	localparam logic [9:0]         MILLI_TO_MICRO = 10'd1000;

	localparam logic [CFG_IDX_W-1:0] REG_BIAS_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_Z = 2'd2;

	typedef struct packed {
		logic load;
		logic diff;
		logic mul;
		logic chk;
		logic step;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} status_t;

endpackage

>>> hdl/gyro_rate_from_delta_angle_top.sv
// Top level: gyro rate from wrapping delta-angle counters.
//
// channel  | direction | handshake          | content
// s_*      | in        | s_tvalid/s_tready  | sample time, angle counts, direct rates
// m_*      | out       | m_tvalid/m_tready  | rates, timestamp; tuser = from_integral
// cfg_*    | in        | cfg_valid/cfg_ready| bias register writes
//
// An accepted item passes the diff, mul and chk setup states, 28 quotient bits of the
// restoring divider (three lanes share one divisor) and the fin result state; then the
// controller is idle again. The result sits in an output register, so a new item is
// taken while the last one waits; a stalled output holds the controller in its final
// step. Reset clears biases and the previous sample; cfg writes are always taken.
module gyro_rate_from_delta_angle_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// sample_time, angle_count_x/y/z, direct_rate_x/y/z
	input  logic [grfda_pkg::IN_DATA_W-1:0]      s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// rate_x, rate_y, rate_z, time_out, 4 zero bits
	output logic [grfda_pkg::OUT_DATA_W-1:0]     m_tdata,
	// from_integral
	output logic [0:0]                           m_tuser,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [grfda_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [grfda_pkg::BIAS_W-1:0]         cfg_data
);

	grfda_pkg::cmd_t    cmd;
	grfda_pkg::status_t status;

	assign cfg_ready = 1'b1;

	grfda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	grfda_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

>>> hdl/grfda_datapath.sv
// Datapath: step and delta extraction, range check, three-lane divider, output register.
module grfda_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  grfda_pkg::cmd_t                     cmd,
	output grfda_pkg::status_t                  status,
	input  logic [grfda_pkg::IN_DATA_W-1:0]     s_tdata,
	input  logic                                cfg_valid,
	input  logic [grfda_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [grfda_pkg::BIAS_W-1:0]        cfg_data,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [grfda_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic [0:0]                          m_tuser
);

	logic signed [grfda_pkg::BIAS_W-1:0]  bias_q [3];

	logic [grfda_pkg::TIME_W-1:0]         t_q;
	logic [grfda_pkg::COUNT_W-1:0]        cnt_q [3];
	logic signed [grfda_pkg::DIRECT_W-1:0] dir_q [3];
	logic [grfda_pkg::TIME_W-1:0]         prev_t_q;
	logic [grfda_pkg::COUNT_W-1:0]        prev_cnt_q [3];

	logic [grfda_pkg::COUNT_W-1:0]        mag_q [3];
	logic                                 neg_q [3];
	logic [grfda_pkg::TIME_W-1:0]         dmag_q;
	logic                                 dneg_q;
	logic                                 base_ok_q;
	logic [grfda_pkg::LIM_W-1:0]          lim_q;
	logic [grfda_pkg::NUM_W-1:0]          num_q [3];
	logic                                 use_int_q;
	logic [grfda_pkg::TIME_W-1:0]         rem_q [3];
	logic [grfda_pkg::QUO_W-1:0]          nsh_q [3];
	logic [grfda_pkg::QUO_W-1:0]          quo_q [3];

	logic signed [grfda_pkg::RATE_W-1:0]  rate_q [3];
	logic                                 from_int_q;
	logic [grfda_pkg::TIME_W-1:0]         time_q;
	logic                                 m_valid_q;

	// combinational per-lane and shared values
	logic [grfda_pkg::COUNT_W-1:0]        d_c [3];
	logic [grfda_pkg::COUNT_W-1:0]        mag_c [3];
	logic                                 neg_c [3];
	logic                                 dneg_c;
	logic [grfda_pkg::TIME_W-1:0]         dmag_c;
	logic                                 exceed_c [3];
	logic [grfda_pkg::TIME_W:0]           r2_c [3];
	logic                                 ge_c [3];
	logic signed [grfda_pkg::RATE_W:0]    qv_c [3];
	logic signed [grfda_pkg::RATE_W:0]    dv_c [3];
	logic signed [grfda_pkg::RATE_W:0]    res_c [3];

	assign status.out_busy = m_valid_q && !m_tready;

	always_comb begin
		dneg_c = t_q < prev_t_q;
		dmag_c = dneg_c ? (prev_t_q - t_q) : (t_q - prev_t_q);
		for (int i = 0; i < 3; i++) begin
			d_c[i] = cnt_q[i] - prev_cnt_q[i];
			if (d_c[i] < grfda_pkg::STEP_LIMIT) begin
				mag_c[i] = d_c[i];
				neg_c[i] = 1'b0;
			end else begin
				mag_c[i] = grfda_pkg::COUNT_W'(33'h1_0000_0000 - {1'b0, d_c[i]});
				neg_c[i] = 1'b1;
			end
			exceed_c[i] = (dmag_q[grfda_pkg::TIME_W-1:grfda_pkg::COUNT_W] == '0)
				&& ({8'b0, mag_q[i]} > lim_q);
			r2_c[i] = {rem_q[i], nsh_q[i][grfda_pkg::QUO_W-1]};
			ge_c[i] = r2_c[i] >= {1'b0, dmag_q};
			qv_c[i] = {{(grfda_pkg::RATE_W + 1 - grfda_pkg::QUO_W){1'b0}}, quo_q[i]};
			if (neg_q[i] != dneg_q)
				qv_c[i] = -qv_c[i];
			dv_c[i] = {{(grfda_pkg::RATE_W + 1 - grfda_pkg::DIRECT_W){dir_q[i][grfda_pkg::DIRECT_W-1]}},
				dir_q[i]};
			dv_c[i] = dv_c[i]
				* $signed((grfda_pkg::RATE_W + 1)'(grfda_pkg::MILLI_TO_MICRO));
			res_c[i] = (use_int_q ? qv_c[i] : dv_c[i])
				- {{(grfda_pkg::RATE_W + 1 - grfda_pkg::BIAS_W){bias_q[i][grfda_pkg::BIAS_W-1]}},
				bias_q[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				bias_q[i]     <= '0;
				prev_cnt_q[i] <= '0;
			end
			prev_t_q  <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					grfda_pkg::REG_BIAS_X: bias_q[0] <= cfg_data;
					grfda_pkg::REG_BIAS_Y: bias_q[1] <= cfg_data;
					grfda_pkg::REG_BIAS_Z: bias_q[2] <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.diff) begin
				prev_t_q <= t_q;
				for (int i = 0; i < 3; i++)
					prev_cnt_q[i] <= cnt_q[i];
			end
			if (cmd.fin)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			t_q <= s_tdata[47:0];
			cnt_q[0] <= s_tdata[79:48];
			cnt_q[1] <= s_tdata[111:80];
			cnt_q[2] <= s_tdata[143:112];
			dir_q[0] <= s_tdata[167:144];
			dir_q[1] <= s_tdata[191:168];
			dir_q[2] <= s_tdata[215:192];
		end
		if (cmd.diff) begin
			dneg_q    <= dneg_c;
			dmag_q    <= dmag_c;
			base_ok_q <= (t_q != '0) && (prev_t_q != '0) && (dmag_c != '0);
			for (int i = 0; i < 3; i++) begin
				mag_q[i] <= mag_c[i];
				neg_q[i] <= neg_c[i];
			end
		end
		if (cmd.mul) begin
			lim_q <= grfda_pkg::LIM_W'(dmag_q[grfda_pkg::COUNT_W-1:0])
				* grfda_pkg::LIM_W'(grfda_pkg::MAX_RATE_RAD);
			for (int i = 0; i < 3; i++)
				num_q[i] <= grfda_pkg::NUM_W'(mag_q[i])
					* grfda_pkg::NUM_W'(grfda_pkg::URAD_PER_RAD);
		end
		if (cmd.chk) begin
			use_int_q <= base_ok_q && !(exceed_c[0] || exceed_c[1] || exceed_c[2]);
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= grfda_pkg::TIME_W'(num_q[i][grfda_pkg::NUM_W-1:grfda_pkg::QUO_W]);
				nsh_q[i] <= num_q[i][grfda_pkg::QUO_W-1:0];
				quo_q[i] <= '0;
			end
		end
		if (cmd.step) begin
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= ge_c[i] ? grfda_pkg::TIME_W'(r2_c[i] - {1'b0, dmag_q})
					: r2_c[i][grfda_pkg::TIME_W-1:0];
				nsh_q[i] <= {nsh_q[i][grfda_pkg::QUO_W-2:0], 1'b0};
				quo_q[i] <= {quo_q[i][grfda_pkg::QUO_W-2:0], ge_c[i]};
			end
		end
		if (cmd.fin) begin
			from_int_q <= use_int_q;
			time_q     <= t_q;
			for (int i = 0; i < 3; i++)
				rate_q[i] <= res_c[i][grfda_pkg::RATE_W-1:0];
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0, time_q, rate_q[2], rate_q[1], rate_q[0]};
	assign m_tuser  = from_int_q;

endmodule

>>> hdl/grfda_ctrl.sv
// Controller: sequences one item through the datapath.
module grfda_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  grfda_pkg::status_t status,
	output grfda_pkg::cmd_t    cmd
);

	localparam int CNT_W = $clog2(grfda_pkg::DIV_STEPS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIFF,
		S_MUL,
		S_CHK,
		S_DIV,
		S_FIN
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (s_tvalid) state_q <= S_DIFF;
				S_DIFF: state_q <= S_MUL;
				S_MUL:  state_q <= S_CHK;
				S_CHK: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(grfda_pkg::DIV_STEPS - 1))
						state_q <= S_FIN;
				end
				S_FIN: if (!status.out_busy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign cmd.load = s_tready && s_tvalid;
	assign cmd.diff = (state_q == S_DIFF);
	assign cmd.mul  = (state_q == S_MUL);
	assign cmd.chk  = (state_q == S_CHK);
	assign cmd.step = (state_q == S_DIV);
	assign cmd.fin  = (state_q == S_FIN) && !status.out_busy;

endmodule

>>> hdl/grfda_checker.sv
// Port-level checker for the gyro rate block, bound to the top level.
`include "gyro_rate_from_delta_angle_top_defines.svh"

module grfda_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_tvalid,
	input logic                                 s_tready,
	input logic [grfda_pkg::IN_DATA_W-1:0]      s_tdata,
	input logic                                 m_tvalid,
	input logic                                 m_tready,
	input logic [grfda_pkg::OUT_DATA_W-1:0]     m_tdata,
	input logic [0:0]                           m_tuser,
	input logic                                 cfg_valid,
	input logic                                 cfg_ready,
	input logic [grfda_pkg::CFG_IDX_W-1:0]      cfg_index,
	input logic [grfda_pkg::BIAS_W-1:0]         cfg_data
);

	// output holds while stalled
	`GRFDA_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled output item changed")

	// one item at a time: busy right after an accept
	`GRFDA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready && !$rose(m_tvalid), "input ready too soon after accept")

	// counter path needs a known timestamp
	`GRFDA_ASSERT_NOW(a_integral_time, clk, arst_n, m_tvalid && m_tuser[0], m_tdata[155:108] != '0, "counter rate with zero timestamp")

	// bias writes are never stalled
	`GRFDA_ASSERT_NOW(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready, "config write stalled")

endmodule

bind gyro_rate_from_delta_angle_top grfda_checker u_grfda_checker (.*);

>>> test/gyro_rate_from_delta_angle_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the gyro rate block: directed, random and backpressure runs.
module gyro_rate_from_delta_angle_top_test;

	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 4;
	localparam int CYCLE_LIMIT  = 800000;
	localparam int DRAIN_CYCLES = 100;
	localparam int HOLD_CYCLES  = 600;
	localparam int AXES         = 3;
	localparam logic [grfda_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [AXES-1:0][grfda_pkg::DIRECT_W-1:0] direct;
		logic [AXES-1:0][grfda_pkg::COUNT_W-1:0]  count;
		logic [grfda_pkg::TIME_W-1:0]             stamp;
	} sample_t;

	typedef struct packed {
		logic [grfda_pkg::OUT_DATA_W-grfda_pkg::RATE_W*AXES-grfda_pkg::TIME_W-1:0] pad;
		logic [grfda_pkg::TIME_W-1:0]                                              stamp;
		logic [AXES-1:0][grfda_pkg::RATE_W-1:0]                                    rate;
	} rate_word_t;

	typedef struct {
		rate_word_t word;
		logic       from_integral;
	} rate_expect_t;

	logic                             clk       = 1'b0;
	logic                             arst_n    = 1'b0;
	logic                             s_tvalid  = 1'b0;
	logic                             s_tready;
	// sample_time, angle_count_x/y/z, direct_rate_x/y/z
	logic [grfda_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
	logic                             m_tvalid;
	logic                             m_tready  = 1'b0;
	// rate_x, rate_y, rate_z, time_out, 4 zero bits
	logic [grfda_pkg::OUT_DATA_W-1:0] m_tdata;
	// from_integral
	logic [0:0]                       m_tuser;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [grfda_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [grfda_pkg::BIAS_W-1:0]     cfg_data  = '0;

	// predictor state
	logic [grfda_pkg::TIME_W-1:0]        last_stamp = '0;
	logic [grfda_pkg::COUNT_W-1:0]       last_count [AXES] = '{default: '0};
	logic signed [grfda_pkg::BIAS_W-1:0] bias_urad [AXES] = '{default: '0};
	rate_expect_t                        pending_rates [$];

	sample_t last_sent      = '0;
	int      send_idle_pct  = 0;
	int      recv_stall_pct = 0;
	logic    hold_ready     = 1'b0;
	int      error_count    = 0;
	int      cycle_count    = 0;

	gyro_rate_from_delta_angle_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("gyro_rate_from_delta_angle_top_test: done, errors");
		$finish;
	end

	always @(posedge clk) begin
		m_tready <= !hold_ready && ($urandom_range(99, 0) >= recv_stall_pct);
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
		error_count++;
	endtask

	function automatic rate_expect_t predict_rates(input sample_t smp);
		rate_expect_t res;
		logic [63:0]  dmag;
		logic [63:0]  q;
		logic [63:0]  mag [AXES];
		logic         neg [AXES];
		logic [grfda_pkg::COUNT_W-1:0] d;
		logic         dneg;
		logic         integral;
		longint       r;
		dneg = smp.stamp < last_stamp;
		dmag = dneg ? {16'd0, last_stamp - smp.stamp} : {16'd0, smp.stamp - last_stamp};
		integral = (smp.stamp != 0) && (last_stamp != 0) && (dmag != 0);
		for (int i = 0; i < AXES; i++) begin
			d = smp.count[i] - last_count[i];
			if (d < grfda_pkg::STEP_LIMIT) begin
				mag[i] = {32'd0, d};
				neg[i] = 1'b0;
			end else begin
				mag[i] = 64'h1_0000_0000 - {32'd0, d};
				neg[i] = 1'b1;
			end
			if (mag[i] > dmag * grfda_pkg::MAX_RATE_RAD)
				integral = 1'b0;
		end
		for (int i = 0; i < AXES; i++) begin
			if (integral) begin
				q = mag[i] * grfda_pkg::URAD_PER_RAD / dmag;
				r = (neg[i] != dneg) ? -longint'(q) : longint'(q);
			end else begin
				r = longint'($signed(smp.direct[i])) * longint'(grfda_pkg::MILLI_TO_MICRO);
			end
			r = r - longint'(bias_urad[i]);
			res.word.rate[i] = r[grfda_pkg::RATE_W-1:0];
			last_count[i] = smp.count[i];
		end
		res.word.pad = '0;
		res.word.stamp = smp.stamp;
		res.from_integral = integral;
		last_stamp = smp.stamp;
		return res;
	endfunction

	always @(posedge clk) begin
		rate_expect_t want;
		rate_word_t   got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_rates.size() == 0) begin
				report_mismatch("result with none pending", 64'(got.stamp), '0);
			end else begin
				want = pending_rates.pop_front();
				for (int i = 0; i < AXES; i++)
					if (got.rate[i] !== want.word.rate[i])
						report_mismatch($sformatf("rate axis %0d", i), 64'(got.rate[i]),
							64'(want.word.rate[i]));
				if (got.stamp !== want.word.stamp)
					report_mismatch("time_out", 64'(got.stamp), 64'(want.word.stamp));
				if (m_tuser[0] !== want.from_integral)
					report_mismatch("from_integral", 64'(m_tuser), 64'(want.from_integral));
			end
		end
	end

	task automatic send_sample(input sample_t smp);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= smp;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_rates.push_back(predict_rates(smp));
		last_sent = smp;
	endtask

	task automatic wait_drained();
		while (pending_rates.size() != 0) @(posedge clk);
	endtask

	task automatic write_bias(input logic [grfda_pkg::CFG_IDX_W-1:0] idx,
			input logic [grfda_pkg::BIAS_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			grfda_pkg::REG_BIAS_X: bias_urad[0] = value;
			grfda_pkg::REG_BIAS_Y: bias_urad[1] = value;
			grfda_pkg::REG_BIAS_Z: bias_urad[2] = value;
			default: ;
		endcase
	endtask

	task automatic set_biases(input logic [grfda_pkg::BIAS_W-1:0] bx,
			input logic [grfda_pkg::BIAS_W-1:0] by, input logic [grfda_pkg::BIAS_W-1:0] bz);
		wait_drained();
		write_bias(grfda_pkg::REG_BIAS_X, bx);
		write_bias(grfda_pkg::REG_BIAS_Y, by);
		write_bias(grfda_pkg::REG_BIAS_Z, bz);
		cfg_valid <= 1'b0;
	endtask

	function automatic sample_t random_sample();
		sample_t smp;
		smp.stamp = grfda_pkg::TIME_W'({$urandom(), $urandom()});
		for (int i = 0; i < AXES; i++) begin
			smp.count[i] = $urandom();
			smp.direct[i] = grfda_pkg::DIRECT_W'($urandom());
		end
		return smp;
	endfunction

	function automatic logic [grfda_pkg::COUNT_W-1:0] walk_count(
			input logic [grfda_pkg::COUNT_W-1:0] c, input longint lim);
		logic [grfda_pkg::COUNT_W-1:0] mag;
		mag = $urandom_range(32'(lim), 0);
		return $urandom_range(1, 0) ? c - mag : c + mag;
	endfunction

	task automatic send_offset(input logic [grfda_pkg::TIME_W-1:0] stamp,
			input logic [grfda_pkg::COUNT_W-1:0] sx, input logic [grfda_pkg::COUNT_W-1:0] sy,
			input logic [grfda_pkg::COUNT_W-1:0] sz);
		sample_t smp;
		smp = random_sample();
		smp.stamp = stamp;
		smp.count[0] = last_sent.count[0] + sx;
		smp.count[1] = last_sent.count[1] + sy;
		smp.count[2] = last_sent.count[2] + sz;
		send_sample(smp);
	endtask

	// mostly steady tracks within the rate limit, plus jumps, stalls and garbage
	task automatic send_random_items(input int n);
		sample_t smp;
		int      kind;
		int      hot;
		longint  delta;
		longint  lim;
		logic [grfda_pkg::COUNT_W-1:0] mag;
		for (int k = 0; k < n; k++) begin
			kind = $urandom_range(99, 0);
			smp = random_sample();
			delta = $urandom_range(3000, 1);
			if (kind >= 78 && kind < 84)
				delta = $urandom_range(32'h0200_0000, 32'h0001_0000);
			lim = longint'(grfda_pkg::MAX_RATE_RAD) * delta;
			if (lim > 64'h8000_0001)
				lim = 64'h8000_0001;
			if (kind < 95) begin
				if (kind >= 70 && kind < 78)
					smp.stamp = last_sent.stamp - grfda_pkg::TIME_W'(delta);
				else if (kind >= 88 && kind < 92)
					smp.stamp = '0;
				else if (kind >= 92)
					smp.stamp = last_sent.stamp;
				else
					smp.stamp = last_sent.stamp + grfda_pkg::TIME_W'(delta);
				for (int i = 0; i < AXES; i++)
					smp.count[i] = walk_count(last_sent.count[i], lim);
				if (kind >= 84 && kind < 88) begin
					hot = $urandom_range(AXES - 1, 0);
					mag = $urandom_range(32'(lim + 1000), 32'(lim + 1));
					smp.count[hot] = $urandom_range(1, 0) ? last_sent.count[hot] - mag :
						last_sent.count[hot] + mag;
				end
			end
			send_sample(smp);
		end
		s_tvalid <= 1'b0;
	endtask

	task automatic random_phase(input int idle_pct, input int stall_pct, input int n);
		set_biases($urandom(), $urandom(), $urandom());
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		send_random_items(n);
	endtask

	task automatic test_directed_cases();
		sample_t smp;
		smp.stamp = 48'd1000;
		smp.count[0] = 32'h0000_0000;
		smp.count[1] = 32'hffff_ffff;
		smp.count[2] = 32'h8000_0000;
		smp.direct[0] = 24'h7f_ffff;
		smp.direct[1] = 24'h80_0000;
		smp.direct[2] = 24'h00_0000;
		send_sample(smp);
		send_offset(48'd2000, 32'd157000, -32'sd157000, 32'd0);
		send_offset(48'd3000, 32'd157001, 32'd5, 32'd5);
		send_offset(48'd3000, 32'd10, 32'd10, 32'd10);
		send_offset(48'd0, 32'd1, 32'd2, 32'd3);
		send_offset(48'd5000, 32'd4, 32'd5, 32'd6);
		// time going backwards
		send_offset(48'd4000, 32'd500, -32'sd500, 32'd157000);
		// step sign boundary
		send_offset(48'd20_004_000, 32'h7fff_fffe, 32'h7fff_ffff, 32'h8000_0000);
		send_offset(48'd20_005_000, 32'hffff_ffff, 32'd1, 32'h0000_0000);
		smp.stamp = 48'hffff_ffff_ffff;
		smp.count[0] = last_sent.count[0] + 32'h8000_0001;
		smp.count[1] = last_sent.count[1] + 32'h7fff_fffe;
		smp.count[2] = last_sent.count[2] + 32'hffff_ffff;
		smp.direct[0] = 24'h80_0000;
		smp.direct[1] = 24'h7f_ffff;
		smp.direct[2] = 24'hff_ffff;
		send_sample(smp);
		send_offset(48'd1, 32'd5, 32'd5, 32'd5);
		send_offset(48'd2, 32'd0, 32'd0, 32'd0);
		send_offset(48'd3, 32'd157, -32'sd157, 32'd158);
		send_offset(48'd4, 32'd157, -32'sd157, 32'd0);
		send_offset(48'd5, 32'h7fff_ffff, 32'd0, 32'd0);
		s_tvalid <= 1'b0;
	endtask

	task automatic test_bias_registers();
		set_biases(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
		send_random_items(12);
		wait_drained();
		write_bias(REG_UNUSED, $urandom());
		write_bias(grfda_pkg::REG_BIAS_Y, 32'h0000_0001);
		cfg_valid <= 1'b0;
		send_random_items(8);
		set_biases(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000);
		send_random_items(8);
	endtask

	task automatic test_streaming_no_idle();
		random_phase(0, 0, 230);
	endtask

	task automatic test_sender_idle();
		random_phase(65, 0, 230);
	endtask

	task automatic test_receiver_stall();
		random_phase(0, 65, 230);
	endtask

	task automatic test_both_idle();
		random_phase(8, 8, 200);
	endtask

	task automatic test_output_backpressure();
		set_biases($urandom(), $urandom(), $urandom());
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fork
			begin
				hold_ready <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_ready <= 1'b0;
			end
			send_random_items(30);
		join
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_bias_registers();
		test_streaming_no_idle();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		test_output_backpressure();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_rates.size() != 0)
			report_mismatch("results never arrived", 64'(pending_rates.size()), '0);
		if (error_count == 0)
			$display("gyro_rate_from_delta_angle_top_test: done, clean");
		else
			$display("gyro_rate_from_delta_angle_top_test: done, errors");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hdl
hdl/grfda_pkg.sv
hdl/grfda_datapath.sv
hdl/grfda_ctrl.sv
hdl/gyro_rate_from_delta_angle_top.sv
hdl/grfda_checker.sv
test/gyro_rate_from_delta_angle_top_test.sv
